// ===== design/pfsp_pkg.sv =====
`timescale 1ns / 1ps
// pfsp_pkg: shared types and codes of the page fault swap policy block
// used by page_fault_swap_policy_core and its port checker
package pfsp_pkg;

  localparam int MaxPages  = 256;
  localparam int MaxFrames = 16;

  // result action codes
  localparam logic [2:0] ACT_MAP_FREE  = 3'd0;
  localparam logic [2:0] ACT_EVICT_MAP = 3'd1;
  localparam logic [2:0] ACT_WRITABLE  = 3'd2;
  localparam logic [2:0] ACT_SWAP_IN   = 3'd3;
  localparam logic [2:0] ACT_NO_SLOT   = 3'd4;
  localparam logic [2:0] ACT_BAD_INDEX = 3'd5;

  // page states
  localparam logic [1:0] PG_UNALLOC = 2'd0;
  localparam logic [1:0] PG_RAM     = 2'd1;
  localparam logic [1:0] PG_SWAP    = 2'd2;

  // protection levels
  localparam logic [1:0] PROT_NO = 2'd0;
  localparam logic [1:0] PROT_RD = 2'd1;
  localparam logic [1:0] PROT_WR = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_FRAMES = 2'd0;
  localparam logic [1:0] CFG_PAGES  = 2'd1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_LOOK,
    S_SCAN_F,
    S_SCAN_S,
    S_EVICT,
    S_MAP,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [1:0] state;
    logic [1:0] prev;
    logic       dirty;
    logic [1:0] prot;
    logic [7:0] loc;
  } page_entry_t;

  typedef struct packed {
    logic [2:0] action;
    logic [3:0] frame;
    logic [7:0] evicted_page;
    logic [7:0] evict_slot;
    logic       writeback;
    logic [7:0] swapin_slot;
    logic [1:0] protection;
  } result_t;

endpackage

// ===== design/page_fault_swap_policy_core.sv =====
`timescale 1ns / 1ps
// page_fault_swap_policy_core: demand paging fault handler with swap slots
// depends on pfsp_pkg
//
// One page fault item is taken at a time and gives one result item. The page
// table sits in a 256-entry synchronous memory with per-entry valid bits
// cleared at reset. Swap slot ownership sits in a second 256-entry
// synchronous memory that a pass over all entries clears after reset, with
// the input stalled meanwhile; frame ownership sits in flops. A bad index and
// a fault on a resident page need no scan. Other faults scan frames one per
// cycle and, if none is free, swap slots one per cycle through the slot
// memory's read pipeline; a fault on a page in swap scans the slots only. A
// new item is taken while the previous result still waits at the output
// register.
module page_fault_swap_policy_core
  import pfsp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] page_index_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] action_o,
  output logic [3:0] frame_o,
  output logic [7:0] evicted_page_o,
  output logic [7:0] evict_slot_o,
  output logic       writeback_o,
  output logic [7:0] swapin_slot_o,
  output logic [1:0] protection_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [8:0] cfg_data_i
);

  state_e state_q, state_d;

  logic [4:0] frames_in_use_q;
  logic [8:0] pages_in_use_q;
  logic [4:0] frame_lim;
  logic [8:0] page_lim;

  logic [7:0]  page_q, page_d;
  page_entry_t entry_q, entry_d;
  logic [8:0]  cnt_q, cnt_d;
  logic [3:0]  frame_q, frame_d;
  logic [7:0]  slot_q, slot_d;
  logic        swap_q, swap_d;
  logic        evicted_q, evicted_d;
  logic        chk_q, chk_d;
  logic [7:0]  chk_idx_q, chk_idx_d;
  result_t     res_q, res_d;
  result_t     out_q, out_d;
  logic        out_valid_q, out_valid_d;
  logic        out_load;

  // page table memory
  page_entry_t pt_mem [MaxPages];
  logic [MaxPages-1:0] pt_valid_q;
  logic        rd_en;
  logic [7:0]  rd_addr;
  page_entry_t rd_data_q;
  logic        rd_hit_q;
  page_entry_t rd_entry;
  logic        wr_en;
  logic [7:0]  wr_addr;
  page_entry_t wr_data;

  // frame ownership flops and swap slot ownership memory
  logic [MaxFrames-1:0] fr_valid_q;
  logic [7:0]           fr_owner_q [MaxFrames];
  logic                 fr_we;
  logic [3:0]           fr_idx;
  logic                 fr_val;
  logic                 sl_mem [MaxPages];
  logic                 sl_we;
  logic [7:0]           sl_idx;
  logic                 sl_val;
  logic                 sl_rd_en;
  logic [7:0]           sl_rd_addr;
  logic                 sl_rd_q;

  logic out_free;
  logic wb_now;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign frame_lim   = (frames_in_use_q > 5'd16) ? 5'd16 : frames_in_use_q;
  assign page_lim    = (pages_in_use_q > 9'd256) ? 9'd256 : pages_in_use_q;
  assign rd_entry    = rd_hit_q ? rd_data_q : '0;
  assign wb_now      = rd_entry.dirty || (rd_entry.prev == PG_UNALLOC);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_in_use_q <= 5'd16;
      pages_in_use_q  <= 9'd256;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_FRAMES) begin
        frames_in_use_q <= cfg_data_i[4:0];
      end else if (cfg_index_i == CFG_PAGES) begin
        pages_in_use_q <= cfg_data_i;
      end
    end
  end

  // page table storage and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pt_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= pt_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_valid_q <= '0;
      rd_hit_q   <= 1'b0;
    end else begin
      if (wr_en) begin
        pt_valid_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit_q <= pt_valid_q[rd_addr];
      end
    end
  end

  // swap slot storage and registered read
  always_ff @(posedge clk_i) begin
    if (sl_we) begin
      sl_mem[sl_idx] <= sl_val;
    end
    if (sl_rd_en) begin
      sl_rd_q <= sl_mem[sl_rd_addr];
    end
  end

  // frame ownership
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_valid_q <= '0;
    end else begin
      if (fr_we) begin
        fr_valid_q[fr_idx] <= fr_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fr_we && fr_val) begin
      fr_owner_q[fr_idx] <= page_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working payload
  always_ff @(posedge clk_i) begin
    page_q    <= page_d;
    entry_q   <= entry_d;
    frame_q   <= frame_d;
    slot_q    <= slot_d;
    swap_q    <= swap_d;
    evicted_q <= evicted_d;
    chk_q     <= chk_d;
    chk_idx_q <= chk_idx_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    page_d     = page_q;
    entry_d    = entry_q;
    cnt_d      = cnt_q;
    frame_d    = frame_q;
    slot_d     = slot_q;
    swap_d     = swap_q;
    evicted_d  = evicted_q;
    chk_d      = 1'b0;
    chk_idx_d  = chk_idx_q;
    res_d      = res_q;
    out_load   = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = page_q;
    wr_en      = 1'b0;
    wr_addr    = page_q;
    wr_data    = entry_q;
    fr_we      = 1'b0;
    fr_idx     = frame_q;
    fr_val     = 1'b0;
    sl_we      = 1'b0;
    sl_idx     = slot_q;
    sl_val     = 1'b0;
    sl_rd_en   = 1'b0;
    sl_rd_addr = cnt_q[7:0];

    case (state_q)
      // clear the slot table after reset, one entry per cycle
      S_CLEAR: begin
        sl_we  = 1'b1;
        sl_idx = cnt_q[7:0];
        sl_val = 1'b0;
        if (cnt_q == 9'd255) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 9'd1;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          page_d  = page_index_i;
          state_d = S_CHECK;
        end
      end

      // range check and page table read
      S_CHECK: begin
        res_d     = '0;
        evicted_d = 1'b0;
        swap_d    = 1'b0;
        if ({1'b0, page_q} >= page_lim) begin
          res_d.action = ACT_BAD_INDEX;
          state_d      = S_RESP;
        end else begin
          rd_en   = 1'b1;
          rd_addr = page_q;
          state_d = S_LOOK;
        end
      end

      // dispatch on the page state
      S_LOOK: begin
        entry_d = rd_entry;
        cnt_d   = '0;
        if (rd_entry.state == PG_RAM) begin
          wr_en            = 1'b1;
          wr_addr          = page_q;
          wr_data          = rd_entry;
          wr_data.prot     = PROT_WR;
          wr_data.dirty    = 1'b1;
          res_d.action     = ACT_WRITABLE;
          res_d.frame      = rd_entry.loc[3:0];
          res_d.protection = PROT_WR;
          state_d          = S_RESP;
        end else if (rd_entry.state == PG_UNALLOC) begin
          state_d = S_SCAN_F;
        end else begin
          swap_d  = 1'b1;
          state_d = S_SCAN_S;
        end
      end

      // first free frame, one per cycle
      S_SCAN_F: begin
        if (cnt_q < {4'b0, frame_lim}) begin
          if (!fr_valid_q[cnt_q[3:0]]) begin
            frame_d = cnt_q[3:0];
            state_d = S_MAP;
          end else begin
            cnt_d = cnt_q + 9'd1;
          end
        end else if (!fr_valid_q[0]) begin
          frame_d = '0;
          state_d = S_MAP;
        end else begin
          cnt_d   = '0;
          state_d = S_SCAN_S;
        end
      end

      // first free swap slot, one read issued and one checked per cycle
      S_SCAN_S: begin
        frame_d = '0;
        if (chk_q && !sl_rd_q) begin
          slot_d = chk_idx_q;
          if (fr_valid_q[0]) begin
            rd_en   = 1'b1;
            rd_addr = fr_owner_q[0];
            state_d = S_EVICT;
          end else begin
            state_d = S_MAP;
          end
        end else if (cnt_q < page_lim) begin
          sl_rd_en   = 1'b1;
          sl_rd_addr = cnt_q[7:0];
          chk_d      = 1'b1;
          chk_idx_d  = cnt_q[7:0];
          cnt_d      = cnt_q + 9'd1;
        end else begin
          res_d.action     = ACT_NO_SLOT;
          res_d.protection = entry_q.prot;
          state_d          = S_RESP;
        end
      end

      // move frame 0's page out to the chosen slot
      S_EVICT: begin
        wr_en              = 1'b1;
        wr_addr            = fr_owner_q[0];
        wr_data.state      = PG_SWAP;
        wr_data.prev       = PG_RAM;
        wr_data.dirty      = 1'b0;
        wr_data.prot       = PROT_NO;
        wr_data.loc        = slot_q;
        sl_we              = 1'b1;
        sl_idx             = slot_q;
        sl_val             = 1'b1;
        fr_we              = 1'b1;
        fr_idx             = '0;
        fr_val             = 1'b0;
        evicted_d          = 1'b1;
        res_d.evicted_page = fr_owner_q[0];
        res_d.evict_slot   = slot_q;
        res_d.writeback    = wb_now;
        state_d            = S_MAP;
      end

      // map the faulting page into its frame
      S_MAP: begin
        wr_en            = 1'b1;
        wr_addr          = page_q;
        wr_data          = entry_q;
        wr_data.state    = PG_RAM;
        wr_data.prot     = PROT_RD;
        fr_we            = 1'b1;
        fr_idx           = frame_q;
        fr_val           = 1'b1;
        res_d.frame      = frame_q;
        res_d.protection = PROT_RD;
        if (swap_q) begin
          sl_we             = 1'b1;
          sl_idx            = entry_q.loc;
          sl_val            = 1'b0;
          wr_data.prev      = PG_SWAP;
          wr_data.loc       = '0;
          res_d.action      = ACT_SWAP_IN;
          res_d.swapin_slot = entry_q.loc;
        end else begin
          wr_data.prev = PG_UNALLOC;
          wr_data.loc  = {4'b0, frame_q};
          res_d.action = evicted_q ? ACT_EVICT_MAP : ACT_MAP_FREE;
        end
        state_d = S_RESP;
      end

      // hand the result to the output register
      S_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_d       = out_load ? res_q : out_q;
    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  assign out_valid_o    = out_valid_q;
  assign action_o       = out_q.action;
  assign frame_o        = out_q.frame;
  assign evicted_page_o = out_q.evicted_page;
  assign evict_slot_o   = out_q.evict_slot;
  assign writeback_o    = out_q.writeback;
  assign swapin_slot_o  = out_q.swapin_slot;
  assign protection_o   = out_q.protection;

endmodule

// ===== design/pfsp_checker.sv =====
`timescale 1ns / 1ps
// pfsp_checker: port level checks of the page fault swap policy block
// depends on pfsp_pkg; bound to page_fault_swap_policy_core
module pfsp_checker
  import pfsp_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] action_o,
  input logic [3:0] frame_o,
  input logic [7:0] evicted_page_o,
  input logic       writeback_o,
  input logic [7:0] swapin_slot_o,
  input logic [1:0] protection_o
);

  // a stalled result item stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(action_o))
    else $error("stalled result item changed");

  // bad index carries no other information
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == ACT_BAD_INDEX |->
      frame_o == 4'd0 && evicted_page_o == 8'd0 && protection_o == PROT_NO)
    else $error("bad index result has nonzero fields");

  // a resident fault leaves the page writable
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == ACT_WRITABLE |-> protection_o == PROT_WR)
    else $error("writable action without write protection");

  // a missing slot moves nothing: no writeback, no swap-in slot, frame 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == ACT_NO_SLOT |->
      writeback_o == 1'b0 && swapin_slot_o == 8'd0 && frame_o == 4'd0)
    else $error("no slot result shows an eviction");

endmodule

bind page_fault_swap_policy_core pfsp_checker u_pfsp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .action_o       (action_o),
  .frame_o        (frame_o),
  .evicted_page_o (evicted_page_o),
  .writeback_o    (writeback_o),
  .swapin_slot_o  (swapin_slot_o),
  .protection_o   (protection_o)
);
